/* hdl/plo_pkg.sv */
`timescale 1ns / 1ps

package plo_pkg;

   // default and largest list depth
   localparam int DefDepth = 32;
   localparam int MaxDepth = 64;

   // slot index width, wide enough for the largest depth
   localparam int SlotW = $clog2(MaxDepth);

   // operation codes
   localparam logic [2:0] OpInsHead = 3'd0;
   localparam logic [2:0] OpInsTail = 3'd1;
   localparam logic [2:0] OpInsPos  = 3'd2;
   localparam logic [2:0] OpDelHead = 3'd3;
   localparam logic [2:0] OpDelTail = 3'd4;
   localparam logic [2:0] OpDelPos  = 3'd5;
   localparam logic [2:0] OpDisplay = 3'd6;

   // status codes
   localparam logic [1:0] StOk     = 2'd0;
   localparam logic [1:0] StEmpty  = 2'd1;
   localparam logic [1:0] StBadPos = 2'd2;
   localparam logic [1:0] StFull   = 2'd3;

   typedef struct packed {
      logic [2:0]         operation;
      logic signed [31:0] element;
      logic [7:0]         position;
   } plo_req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] value;
      logic [5:0]         index;
      logic               last;
   } plo_rsp_type;

   // what every cell does with its stored value
   typedef enum logic [1:0] {
      CellHold,
      CellInsert,
      CellDelete,
      CellRotate
   } plo_mode_type;

   // command broadcast along the chain
   typedef struct packed {
      plo_mode_type     mode;
      logic [SlotW-1:0] slot;
   } plo_cmd_type;

   typedef enum logic {
      StateIdle,
      StateDisplay
   } plo_state_type;

endpackage

/* hdl/plo_cell.sv */
`timescale 1ns / 1ps

module plo_cell
   import plo_pkg::*;
#(
   parameter int IDX = 0
) (
   input  logic               clock,
   input  plo_cmd_type        cmd,
   input  logic signed [31:0] element,
   input  logic signed [31:0] left_value,
   input  logic signed [31:0] right_value,
   input  logic signed [31:0] head_value,
   output logic signed [31:0] value
);

   localparam logic [SlotW-1:0] Pos = SlotW'(IDX);

   logic signed [31:0] value_ff;
   logic signed [31:0] value_in;

   // pick the next value from the neighbors
   always_comb begin
      value_in = value_ff;
      case (cmd.mode)
         CellInsert: begin
            if (Pos > cmd.slot) begin
               value_in = left_value;
            end else if (Pos == cmd.slot) begin
               value_in = element;
            end
         end
         CellDelete: begin
            if (Pos >= cmd.slot) begin
               value_in = right_value;
            end
         end
         CellRotate: begin
            // the tail cell wraps the head around
            if (Pos == cmd.slot) begin
               value_in = head_value;
            end else begin
               value_in = right_value;
            end
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

/* hdl/positional_ordered_list.sv */
`timescale 1ns / 1ps

// channel | dir | handshake             | beat
// req     | in  | req_valid / req_ready | plo_req_type: operation, element, position
// rsp     | out | rsp_valid / rsp_ready | plo_rsp_type: status, value, index, last
//
// Insert and delete shift every cell of the chain at once.
// Display sends one beat per stored value; the chain
// rotates by one cell per beat and is back in order after the last one.
// Reset clears the length, the count, the state and the output valid flag; cells and output data keep junk.
// A stalled rsp holds the output register; req_ready drops until it frees up.

module positional_ordered_list
   import plo_pkg::*;
#(
   parameter int DEPTH = DefDepth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  plo_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output plo_rsp_type rsp_data
);

   localparam int LenW = $clog2(DEPTH + 1);
   localparam int CntW = $clog2(DEPTH);

   plo_state_type      state_ff;
   plo_state_type      state_in;
   logic [LenW-1:0]    len_ff;
   logic [LenW-1:0]    len_in;
   logic [CntW-1:0]    count_ff;
   logic [CntW-1:0]    count_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   plo_rsp_type        rsp_data_ff;
   plo_rsp_type        rsp_data_in;
   logic               load;
   plo_cmd_type        cmd;
   logic               out_free;
   logic               accept;
   logic               full;
   logic               empty;
   logic               disp_last;
   logic [8:0]         pos9;
   logic [8:0]         len9;
   logic [SlotW-1:0]   tail_slot;
   logic signed [31:0] cell_value [DEPTH];

   // cell chain
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic signed [31:0] left_value;
      logic signed [31:0] right_value;

      if (g == 0) begin : g_first
         assign left_value = req_data.element;
      end else begin : g_mid_left
         assign left_value = cell_value[g-1];
      end

      if (g == DEPTH - 1) begin : g_tail
         assign right_value = cell_value[g];
      end else begin : g_mid_right
         assign right_value = cell_value[g+1];
      end

      plo_cell #(
         .IDX(g)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .element    (req_data.element),
         .left_value (left_value),
         .right_value(right_value),
         .head_value (cell_value[0]),
         .value      (cell_value[g])
      );
   end

   // shared decode terms
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign full      = (len_ff == LenW'(DEPTH));
   assign empty     = (len_ff == '0);
   assign pos9      = {1'b0, req_data.position};
   assign len9      = 9'(len_ff);
   assign tail_slot = SlotW'(len_ff - LenW'(1));
   assign disp_last = ((LenW'(count_ff) + LenW'(1)) == len_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         StateIdle: begin
            if (accept && req_data.operation == OpDisplay && !empty) begin
               state_in = StateDisplay;
            end
         end
         StateDisplay: begin
            if (out_free && disp_last) begin
               state_in = StateIdle;
            end
         end
         default: begin
            state_in = StateIdle;
         end
      endcase
   end

   // outputs, chain command and counters
   always_comb begin
      req_ready   = 1'b0;
      cmd.mode    = CellHold;
      cmd.slot    = '0;
      load        = 1'b0;
      rsp_data_in = '0;
      len_in      = len_ff;
      count_in    = count_ff;
      unique case (state_ff)
         StateIdle: begin
            req_ready = out_free;
            if (accept) begin
               rsp_data_in.last = 1'b1;
               case (req_data.operation)
                  OpInsHead, OpInsTail: begin
                     load = 1'b1;
                     if (full) begin
                        rsp_data_in.status = StFull;
                     end else begin
                        cmd.mode = CellInsert;
                        cmd.slot = (req_data.operation == OpInsHead) ? '0 :
                                   SlotW'(len_ff);
                        len_in   = len_ff + LenW'(1);
                     end
                  end
                  OpInsPos: begin
                     load = 1'b1;
                     if (pos9 == '0 || pos9 > len9 + 9'd1) begin
                        rsp_data_in.status = StBadPos;
                     end else if (full) begin
                        rsp_data_in.status = StFull;
                     end else begin
                        cmd.mode = CellInsert;
                        cmd.slot = SlotW'(req_data.position - 8'd1);
                        len_in   = len_ff + LenW'(1);
                     end
                  end
                  OpDelHead, OpDelTail: begin
                     load = 1'b1;
                     if (empty) begin
                        rsp_data_in.status = StEmpty;
                     end else begin
                        cmd.mode = CellDelete;
                        cmd.slot = (req_data.operation == OpDelHead) ? '0 : tail_slot;
                        len_in   = len_ff - LenW'(1);
                     end
                  end
                  OpDelPos: begin
                     load = 1'b1;
                     if (empty) begin
                        rsp_data_in.status = StEmpty;
                     end else if (pos9 == '0 || pos9 > len9) begin
                        rsp_data_in.status = StBadPos;
                     end else begin
                        cmd.mode = CellDelete;
                        cmd.slot = SlotW'(req_data.position - 8'd1);
                        len_in   = len_ff - LenW'(1);
                     end
                  end
                  OpDisplay: begin
                     count_in = '0;
                     if (empty) begin
                        load               = 1'b1;
                        rsp_data_in.status = StEmpty;
                     end
                  end
                  default: begin
                     load = 1'b0;
                  end
               endcase
            end
         end
         StateDisplay: begin
            // one beat per value, rotating the head out
            if (out_free) begin
               load               = 1'b1;
               rsp_data_in.status = StOk;
               rsp_data_in.value  = cell_value[0];
               rsp_data_in.index  = 6'(count_ff);
               rsp_data_in.last   = disp_last;
               cmd.mode           = CellRotate;
               cmd.slot           = tail_slot;
               count_in           = count_ff + CntW'(1);
            end
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // output register
   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StateIdle;
         len_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* bench/tb_positional_ordered_list.sv */
`timescale 1ns / 1ps

module tb_positional_ordered_list;
   import plo_pkg::*;

   // code the block ignores
   localparam logic [2:0] OpUnused = 3'd7;

   localparam int NumProbes   = 24;
   localparam int RandomItems = 106;
   localparam int QuietLimit  = 2000;
   localparam int LongHold    = 80;
   localparam int DrainCycles = 40;

   // one row of the directed table; status is only meaningful when typed is set
   typedef struct packed {
      logic [2:0]         operation;
      logic signed [31:0] element;
      logic [7:0]         position;
      logic               typed;
      logic [1:0]         status;
   } probe_row_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   plo_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   plo_rsp_type rsp_data;

   // predictor state and beats still owed by the block
   logic signed [31:0] stored_values [$];
   plo_rsp_type        pending_beats [$];

   int unsigned mismatch_count = 0;
   int unsigned quiet_cycles = 0;
   logic        no_idle = 1'b0;
   logic        hold_long = 1'b0;

   probe_row_type probe_rows [NumProbes] = '{
      '{OpDisplay, 32'sh0,        8'd0,   1'b1, StEmpty},
      '{OpDelHead, 32'sh0,        8'd0,   1'b1, StEmpty},
      '{OpDelTail, 32'sh0,        8'd0,   1'b1, StEmpty},
      '{OpDelPos,  32'sh0,        8'd0,   1'b1, StEmpty},
      '{OpInsPos,  32'sh5,        8'd0,   1'b1, StBadPos},
      '{OpInsPos,  32'sh5,        8'd2,   1'b1, StBadPos},
      '{OpInsHead, 32'sh7fffffff, 8'd0,   1'b1, StOk},
      '{OpInsTail, 32'sh80000000, 8'd0,   1'b1, StOk},
      '{OpInsPos,  32'shffffffff, 8'd2,   1'b0, StOk},
      '{OpInsPos,  32'sh0,        8'd4,   1'b0, StOk},
      '{OpDisplay, 32'sh0,        8'd0,   1'b0, StOk},
      '{OpDelPos,  32'sh0,        8'd5,   1'b1, StBadPos},
      '{OpDelPos,  32'sh0,        8'd0,   1'b1, StBadPos},
      '{OpDelPos,  32'sh0,        8'hff,  1'b1, StBadPos},
      '{OpInsPos,  32'sh12345678, 8'hff,  1'b1, StBadPos},
      '{OpUnused,  32'shffffffff, 8'hff,  1'b0, StOk},
      '{OpDelPos,  32'sh0,        8'd2,   1'b0, StOk},
      '{OpInsPos,  32'sha5a5a5a5, 8'd1,   1'b0, StOk},
      '{OpDelPos,  32'sh0,        8'd4,   1'b0, StOk},
      '{OpDelHead, 32'sh0,        8'd0,   1'b0, StOk},
      '{OpDelTail, 32'sh0,        8'd0,   1'b0, StOk},
      '{OpDisplay, 32'sh0,        8'd0,   1'b0, StOk},
      '{OpInsHead, 32'sh5a5a5a5a, 8'd0,   1'b0, StOk},
      '{OpDisplay, 32'sh0,        8'd0,   1'b0, StOk}
   };

   positional_ordered_list #(
      .DEPTH(DefDepth)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // apply one operation to the shadow list and queue the beats it owes
   function automatic void apply_list_op(input plo_req_type beat);
      plo_rsp_type resp;
      int unsigned len;
      int unsigned pos;
      len = stored_values.size();
      pos = beat.position;
      resp = '{StOk, 32'sh0, 6'd0, 1'b1};
      case (beat.operation)
         OpInsHead, OpInsTail: begin
            if (len >= DefDepth) resp.status = StFull;
            else if (beat.operation == OpInsHead) stored_values.push_front(beat.element);
            else stored_values.push_back(beat.element);
         end
         OpInsPos: begin
            if (pos == 0 || pos > len + 1) resp.status = StBadPos;
            else if (len >= DefDepth) resp.status = StFull;
            else stored_values.insert(pos - 1, beat.element);
         end
         OpDelHead, OpDelTail: begin
            if (len == 0) resp.status = StEmpty;
            else if (beat.operation == OpDelHead) void'(stored_values.pop_front());
            else void'(stored_values.pop_back());
         end
         OpDelPos: begin
            if (len == 0) resp.status = StEmpty;
            else if (pos == 0 || pos > len) resp.status = StBadPos;
            else stored_values.delete(pos - 1);
         end
         OpDisplay: begin
            if (len == 0) begin
               resp.status = StEmpty;
            end else begin
               for (int i = 0; i < len; i++) begin
                  pending_beats.push_back('{StOk, stored_values[i], 6'(i), i == len - 1});
               end
               return;
            end
         end
         default: return;
      endcase
      pending_beats.push_back(resp);
   endfunction

   // random operation; mode 0 fills, 1 drains, 2 is even
   function automatic plo_req_type random_beat(input int unsigned mode);
      int unsigned cut [3][8] = '{
         '{30, 55, 85, 89, 92, 95, 99, 100},
         '{3, 6, 9, 40, 65, 90, 98, 100},
         '{14, 28, 42, 56, 70, 84, 98, 100}
      };
      logic [2:0] op_order [8] = '{OpInsHead, OpInsTail, OpInsPos, OpDelHead,
                                   OpDelTail, OpDelPos, OpDisplay, OpUnused};
      logic signed [31:0] extremes [4] = '{32'sh7fffffff, 32'sh80000000, 32'sh0, -32'sh1};
      plo_req_type beat;
      int unsigned r;
      int unsigned k;
      int unsigned top;
      r = $urandom_range(0, 99);
      k = 0;
      while (r >= cut[mode][k]) k++;
      beat.operation = op_order[k];
      if ($urandom_range(0, 7) == 0) beat.element = extremes[$urandom_range(0, 3)];
      else beat.element = $urandom;
      // mostly a legal position, some zero, some anywhere
      top = (beat.operation == OpDelPos) ? stored_values.size() : stored_values.size() + 1;
      r = $urandom_range(0, 9);
      if (r == 0) beat.position = 8'd0;
      else if (r == 1 || top == 0) beat.position = 8'($urandom_range(0, 255));
      else beat.position = 8'($urandom_range(1, top));
      return beat;
   endfunction

   // offer one beat after a random gap; predict once it is taken
   task automatic offer_beat(input plo_req_type beat, input logic typed,
                             input logic [1:0] typed_status);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= beat;
      do @(posedge clock); while (!req_ready);
      apply_list_op(beat);
      if (typed) pending_beats[pending_beats.size() - 1] = '{typed_status, 32'sh0, 6'd0, 1'b1};
   endtask

   // stimulus: reset, directed table, then random sequences
   initial begin
      plo_req_type beat;
      int unsigned counted;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (probe_rows[i]) begin
         beat = '{probe_rows[i].operation, probe_rows[i].element, probe_rows[i].position};
         offer_beat(beat, probe_rows[i].typed, probe_rows[i].status);
      end

      // back up the result side early so the block stalls its input
      hold_long = 1'b1;
      counted = 0;
      while (counted < RandomItems) begin
         no_idle = (counted >= 20 && counted < 35);
         beat = random_beat(counted < 50 ? 0 : (counted < 90 ? 1 : 2));
         offer_beat(beat, 1'b0, StOk);
         if (beat.operation != OpUnused) counted++;
      end
      no_idle = 1'b0;
      req_valid <= 1'b0;

      while (pending_beats.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // result side: random stall before each beat, one long hold-off
   initial begin
      int unsigned stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 3);
         if (hold_long) begin
            stall = LongHold;
            hold_long = 1'b0;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // compare each taken beat with the oldest one owed
   always @(posedge clock) begin
      plo_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_beats.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected beat: status %0d value %0d index %0d last %0b",
                     $time, rsp_data.status, rsp_data.value, rsp_data.index,
                     rsp_data.last);
         end else begin
            want = pending_beats.pop_front();
            if (rsp_data.status !== want.status || rsp_data.value !== want.value ||
                rsp_data.index !== want.index || rsp_data.last !== want.last) begin
               mismatch_count++;
               $display("%0t: mismatch: expected status %0d value %0d index %0d last %0b",
                        $time, want.status, want.value, want.index, want.last);
               $display("%0t:           actual status %0d value %0d index %0d last %0b",
                        $time, rsp_data.status, rsp_data.value, rsp_data.index,
                        rsp_data.last);
            end
         end
      end
   end

   // watchdog on cycles where no beat moves on either side
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
         $display("%0t: watchdog: no beat moved for %0d cycles", $time, quiet_cycles);
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
